[sv/dsd_pkg.sv]
// Shared types and constants for the diagonal swerve kinematics core.
// Holds the CORDIC angle table, the divider width and the side-band struct.
// No dependencies.
`default_nettype none
package dsd_pkg;

    localparam int DIV_BITS = 25;   // quotient bits of the yaw divider

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef logic signed [17:0] t_trig;
    typedef logic signed [16:0] t_rate;
    typedef logic signed [23:0] t_yaw;

    // Items that ride along with the yaw division.
    typedef struct packed {
        logic  neg;     // numerator negative
        logic  nz;      // numerator nonzero
        logic  szero;   // offset sum zero
        t_rate wx;
        t_rate wy;
    } t_side;

    function automatic logic signed [33:0] atan_turn32(input int idx);
        logic signed [33:0] v;
        case (idx)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933405;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10679838;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[sv/dsd_cordic.sv]
// Pipelined rotation-mode CORDIC: binary angle in, rounded Q.16 cos/sin out.
// Input register, rotation stages and output register all advance on the clock enable. Depends on dsd_pkg.
`default_nettype none
module dsd_cordic #(
    parameter int STAGES = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_ce,
    input  wire logic [15:0]   i_angle,
    output dsd_pkg::t_trig     o_cos,
    output dsd_pkg::t_trig     o_sin
);
    import dsd_pkg::*;

    logic signed [33:0] r_x [STAGES+1];
    logic signed [33:0] r_y [STAGES+1];
    logic signed [33:0] r_z [STAGES+1];
    logic               r_f [STAGES+1];
    t_trig              r_cos, r_sin;

    logic               flip;
    logic [31:0]        z32;
    logic signed [33:0] n_cr, n_sr;

    // quadrants 1 and 2 are folded by a half turn
    assign flip = i_angle[15] ^ i_angle[14];
    assign z32  = {i_angle[15] ^ flip, i_angle[14:0], 16'd0};

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x[0] <= CORDIC_X0;
            r_y[0] <= '0;
            r_z[0] <= {{2{z32[31]}}, z32};
            r_f[0] <= flip;
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_f[k+1] <= r_f[k];
                if (!r_z[k][33]) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - atan_turn32(k);
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + atan_turn32(k);
                end
            end
        end
    end

    assign n_cr = (r_x[STAGES] + 34'sd8192) >>> 14;
    assign n_sr = (r_y[STAGES] + 34'sd8192) >>> 14;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_cos <= r_f[STAGES] ? -n_cr[17:0] : n_cr[17:0];
            r_sin <= r_f[STAGES] ? -n_sr[17:0] : n_sr[17:0];
        end
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

    // z is never used past the last stage
    logic unused_z;
    assign unused_z = ^r_z[STAGES];

endmodule
`default_nettype wire

[sv/dsd_div.sv]
// Pipelined restoring divider, one quotient bit per stage, side band carried.
// Every step advances only on the clock enable. Depends on dsd_pkg.
`default_nettype none
module dsd_div (
    input  wire logic                   i_clk,
    input  wire logic                   i_ce,
    input  wire logic [dsd_pkg::DIV_BITS-1:0] i_dividend,
    input  wire logic [15:0]            i_divisor,
    input  wire dsd_pkg::t_side         i_side,
    output logic [dsd_pkg::DIV_BITS-1:0] o_quot,
    output dsd_pkg::t_side              o_side
);
    import dsd_pkg::*;

    logic [15:0]         r_rem [DIV_BITS+1];
    logic [DIV_BITS-1:0] r_dd  [DIV_BITS+1];
    logic [DIV_BITS-1:0] r_q   [DIV_BITS+1];
    logic [15:0]         r_dv  [DIV_BITS+1];
    t_side               r_sd  [DIV_BITS+1];

    always_comb begin
        r_rem[0] = '0;
        r_dd[0]  = i_dividend;
        r_q[0]   = '0;
        r_dv[0]  = i_divisor;
        r_sd[0]  = i_side;
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
        logic [16:0] trial;
        assign trial = {r_rem[k], r_dd[k][DIV_BITS-1-k]};
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_dd[k+1] <= r_dd[k];
                r_dv[k+1] <= r_dv[k];
                r_sd[k+1] <= r_sd[k];
                if (trial >= {1'b0, r_dv[k]}) begin
                    r_rem[k+1] <= 16'(trial - {1'b0, r_dv[k]});
                    r_q[k+1]   <= {r_q[k][DIV_BITS-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= trial[15:0];
                    r_q[k+1]   <= {r_q[k][DIV_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quot = r_q[DIV_BITS];
    assign o_side = r_sd[DIV_BITS];

    logic unused_tail;
    assign unused_tail = ^{r_rem[DIV_BITS], r_dd[DIV_BITS], r_dv[DIV_BITS]};

endmodule
`default_nettype wire

[sv/diagonal_swerve_dynamics_core.sv]
// Diagonal swerve forward kinematics, fully pipelined.
// Every request passes from request accept to result valid through
// CORDIC_STAGES + 32 register stages (CORDIC_STAGES+2 trig, 4 product/rotate,
// 25 divider, 1 output).
// Throughput: one request per cycle; the whole pipe stalls only when the
// output register is full and not taken. Reset (sync, active low) empties
// the pipe and sets both offsets to 256.
`default_nettype none
module diagonal_swerve_dynamics_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_heading,
    input  wire logic [15:0] i_front_left_speed,
    input  wire logic [15:0] i_rear_right_speed,
    input  wire logic [15:0] i_front_left_steer,
    input  wire logic [15:0] i_rear_right_steer,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output dsd_pkg::t_rate   o_world_x_rate,
    output dsd_pkg::t_rate   o_world_y_rate,
    output dsd_pkg::t_yaw    o_yaw_rate
);
    import dsd_pkg::*;

    localparam int LC    = CORDIC_STAGES + 2;
    localparam int TOTAL = LC + 4 + DIV_BITS + 1;

    localparam logic [1:0] REG_LEFT  = 2'd0;
    localparam logic [1:0] REG_RIGHT = 2'd1;

    localparam t_yaw YAW_MAX = 24'sh7FFFFF;
    localparam t_yaw YAW_MIN = 24'sh800000;

    // ---------------- config registers ----------------
    logic [14:0] r_left, r_right;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= 15'd256;
            r_right <= 15'd256;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == REG_LEFT)  r_left  <= i_cfg_data;
            if (i_cfg_index == REG_RIGHT) r_right <= i_cfg_data;
        end
    end

    // ---------------- global stall ----------------
    // every stage moves together; only a full, untaken output holds the pipe
    logic ce;
    logic [TOTAL-1:0] r_vld;
    assign ce         = !r_vld[TOTAL-1] || i_out_ready;
    assign o_in_ready = ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[TOTAL-2:0], i_in_valid};
        end
    end
    assign o_out_valid = r_vld[TOTAL-1];

    // ---------------- trig lanes ----------------
    t_trig th_c, th_s, fl_c, fl_s, rr_c, rr_s;

    dsd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_th (
        .i_clk(i_clk), .i_ce(ce), .i_angle(i_heading), .o_cos(th_c), .o_sin(th_s)
    );
    dsd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_fl (
        .i_clk(i_clk), .i_ce(ce), .i_angle(i_front_left_steer), .o_cos(fl_c), .o_sin(fl_s)
    );
    dsd_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_rr (
        .i_clk(i_clk), .i_ce(ce), .i_angle(i_rear_right_steer), .o_cos(rr_c), .o_sin(rr_s)
    );

    // speeds wait alongside the CORDIC lanes
    logic signed [15:0] r_vfl [LC];
    logic signed [15:0] r_vrr [LC];
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_vfl[0] <= i_front_left_speed;
            r_vrr[0] <= i_rear_right_speed;
            for (int k = 1; k < LC; k++) begin
                r_vfl[k] <= r_vfl[k-1];
                r_vrr[k] <= r_vrr[k-1];
            end
        end
    end

    // ---------------- P1: wheel components (Q.24) ----------------
    logic signed [33:0] r_cfl, r_sfl, r_crr, r_srr;
    t_trig r_thc1, r_ths1;
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cfl  <= r_vfl[LC-1] * fl_c;
            r_sfl  <= r_vfl[LC-1] * fl_s;
            r_crr  <= r_vrr[LC-1] * rr_c;
            r_srr  <= r_vrr[LC-1] * rr_s;
            r_thc1 <= th_c;
            r_ths1 <= th_s;
        end
    end

    // ---------------- P2: twice body velocity, yaw numerator ----------------
    logic signed [34:0] r_sx, r_sy, r_num;
    t_trig r_thc2, r_ths2;
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sx   <= 35'(r_cfl) + 35'(r_crr);
            r_sy   <= 35'(r_sfl) + 35'(r_srr);
            r_num  <= 35'(r_crr) - 35'(r_cfl);
            r_thc2 <= r_thc1;
            r_ths2 <= r_ths1;
        end
    end

    // ---------------- P3: rotation products, divider operands ----------------
    // (|num| + 128*S) / (256*S) == ((|num| + 128*S) >> 8) / S
    logic signed [52:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic [DIV_BITS-1:0] r_div3;
    logic [15:0]         r_sum3;
    logic                r_neg3, r_nz3;
    logic [15:0]         osum;
    logic [34:0]         mag;
    logic [35:0]         dvd;
    assign osum = {1'b0, r_left} + {1'b0, r_right};
    assign mag  = r_num[34] ? 35'(-r_num) : 35'(r_num);
    assign dvd  = {1'b0, mag} + {13'd0, osum, 7'd0};

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pxc  <= r_sx * r_thc2;
            r_pys  <= r_sy * r_ths2;
            r_pxs  <= r_sx * r_ths2;
            r_pyc  <= r_sy * r_thc2;
            r_div3 <= dvd[8 +: DIV_BITS];
            r_sum3 <= osum;
            r_neg3 <= r_num[34];
            r_nz3  <= (r_num != '0);
        end
    end

    // ---------------- P4: world rates with rounding and clamp ----------------
    function automatic t_rate clamp_rate(input logic signed [54:0] v);
        logic signed [54:0] s;
        s = (v + 55'sd4294967296) >>> 33;
        if (s > 55'sd65535)       return 17'sd65535;
        else if (s < -55'sd65536) return -17'sd65536;
        else                      return s[16:0];
    endfunction

    t_side               r_side4;
    logic [DIV_BITS-1:0] r_div4;
    logic [15:0]         r_sum4;
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side4.wx    <= clamp_rate(55'(r_pxc) - 55'(r_pys));
            r_side4.wy    <= clamp_rate(55'(r_pxs) + 55'(r_pyc));
            r_side4.neg   <= r_neg3;
            r_side4.nz    <= r_nz3;
            r_side4.szero <= (r_sum3 == '0);
            r_div4        <= r_div3;
            r_sum4        <= r_sum3;
        end
    end

    // ---------------- yaw division ----------------
    logic [DIV_BITS-1:0] quot;
    t_side               side_q;
    dsd_div u_div (
        .i_clk(i_clk), .i_ce(ce), .i_dividend(r_div4), .i_divisor(r_sum4),
        .i_side(r_side4), .o_quot(quot), .o_side(side_q)
    );

    // ---------------- output register ----------------
    t_yaw n_yaw;
    logic big;
    assign big = (quot[DIV_BITS-1:23] != '0);
    always_comb begin
        if (side_q.szero)
            n_yaw = side_q.nz ? (side_q.neg ? YAW_MIN : YAW_MAX) : '0;
        else if (side_q.neg)
            n_yaw = big ? YAW_MIN : -t_yaw'({1'b0, quot[22:0]});
        else
            n_yaw = big ? YAW_MAX : t_yaw'({1'b0, quot[22:0]});
    end

    t_rate r_wx, r_wy;
    t_yaw  r_yaw;
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_wx  <= side_q.wx;
            r_wy  <= side_q.wy;
            r_yaw <= n_yaw;
        end
    end
    assign o_world_x_rate = r_wx;
    assign o_world_y_rate = r_wy;
    assign o_yaw_rate     = r_yaw;

    // ---------------- assertions ----------------
    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("pipe not empty after reset");

    a_stall_only_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    a_zero_offset_yaw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ce && r_vld[TOTAL-2] && side_q.szero && side_q.nz)
        |=> (o_yaw_rate == YAW_MAX || o_yaw_rate == YAW_MIN))
        else $error("zero offset sum must saturate yaw");

endmodule
`default_nettype wire
